@@ rtl/lstg_pkg.sv @@
`default_nettype none
package lstg_pkg;

   localparam int unsigned MaxChannelDefault = 125;
   localparam int unsigned MaxSlotsDefault   = 6;

   localparam int unsigned CsrIndexW = 3;
   localparam int unsigned CsrDataW  = 32;

   localparam logic [CsrIndexW-1:0] CSR_PPS      = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_DURATION = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_CHANNEL  = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_RATE     = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_SEED     = 3'd4;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] now_ms;
      logic [7:0]  energy;
      logic        replay_busy;
   } req_type;

   typedef struct packed {
      logic        dropped;
      logic [31:0] sequence_res;
      logic [3:0]  latency_ms;
      logic [6:0]  packet_channel;
      logic [1:0]  packet_rate;
      logic [63:0] timestamp_ms;
      logic [31:0] received_total;
      logic [31:0] lost_total;
      logic [3:0]  latency_mean;
      logic [3:0]  latency_peak;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] drop_limit(input logic [7:0] e);
      logic [7:0] lim;
      if (e >= 8'd220)      lim = 8'd204;
      else if (e >= 8'd200) lim = 8'd153;
      else if (e >= 8'd180) lim = 8'd102;
      else if (e >= 8'd160) lim = 8'd64;
      else if (e >= 8'd120) lim = 8'd30;
      else                  lim = 8'd12;
      return lim;
   endfunction

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] a;
      logic [31:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage
`default_nettype wire

@@ rtl/link_stress_traffic_generator.sv @@
`default_nettype none
// Link stress traffic generator. Commands (start, stop, tick) arrive one at a
// time on req; a tick emits up to MAX_SLOTS_PER_TICK slot results on rsp, the
// final one flagged by last. req_ready is high only while the block is idle.
// Start, stop and ignored ticks are handled in S_IDLE. An active tick first runs
// a 10-step radix-2 division for the slot interval (1000/pps, pps clamped to
// 1..1000), then each slot is drawn in S_SLOT, runs the running-mean division
// when the slot is delivered after the first delivery, and waits in S_OUT for
// rsp_ready. Both divisions use the single shared restoring divider.
module link_stress_traffic_generator
   import lstg_pkg::*;
#(
   parameter int unsigned MAX_CHANNEL        = MaxChannelDefault,
   parameter int unsigned MAX_SLOTS_PER_TICK = MaxSlotsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_data
);

   localparam int unsigned SlotW   = $clog2(MAX_SLOTS_PER_TICK + 1);
   localparam int unsigned DivW    = 10;
   localparam int unsigned DivCntW = $clog2(DivW + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_INTDIV, S_CHECK, S_SLOT, S_MEANDIV, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [9:0]  pps_ff, pps_in;
   logic [31:0] dur_ff, dur_in;
   logic [6:0]  chan_ff, chan_in;
   logic [1:0]  rate_ff, rate_in;
   logic [31:0] rng_ff, rng_in;

   logic        running_ff, running_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] next_ff, next_in;
   logic [31:0] sent_ff, sent_in;
   logic [31:0] recv_ff, recv_in;
   logic [31:0] lost_ff, lost_in;
   logic [3:0]  mean_ff, mean_in;
   logic [3:0]  peak_ff, peak_in;

   logic [63:0] now_ff, now_in;
   logic [7:0]  energy_ff, energy_in;
   logic [9:0]  interval_ff, interval_in;
   logic [SlotW-1:0] n_ff, n_in;
   logic        drop_ff, drop_in;
   logic [3:0]  lat_ff, lat_in;
   logic        neg_ff, neg_in;

   // shared restoring divider
   logic [31:0] rem_ff, rem_in;
   logic [DivW-1:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [32:0] trial;
   logic        trial_ge;
   logic [31:0] rem_step;
   logic [DivW-1:0] dvd_step;

   logic [9:0]  pps_clamp;
   logic [6:0]  chan_sat;
   logic        slot_due;
   logic        more_due;
   logic        is_last;
   logic [31:0] x;
   logic        drop_now;
   logic [3:0]  lat_now;
   logic [31:0] recv_next;
   logic signed [4:0] diff;
   logic [3:0]  diff_mag;
   logic [3:0]  q_mag;
   logic [3:0]  q_signed;
   logic [SlotW:0] n_plus;

   always_comb begin
      trial    = {rem_ff, dvd_ff[DivW-1]} - {1'b0, dsr_ff};
      trial_ge = !trial[32];
      rem_step = trial_ge ? trial[31:0] : {rem_ff[30:0], dvd_ff[DivW-1]};
      dvd_step = {dvd_ff[DivW-2:0], trial_ge};
   end

   always_comb begin
      if (pps_ff == 10'd0)         pps_clamp = 10'd1;
      else if (pps_ff > 10'd1000)  pps_clamp = 10'd1000;
      else                         pps_clamp = pps_ff;
      if ({1'b0, chan_ff} > 8'(MAX_CHANNEL)) chan_sat = 7'(MAX_CHANNEL);
      else                                   chan_sat = chan_ff;
   end

   assign slot_due = (next_ff != 64'd0) && (now_ff >= next_ff);
   assign n_plus   = {1'b0, n_ff} + (SlotW+1)'(1);
   assign more_due = (n_plus < (SlotW+1)'(MAX_SLOTS_PER_TICK)) && slot_due;
   assign is_last  = !more_due;

   always_comb begin
      x         = xorshift32(rng_ff);
      drop_now  = x[7:0] < drop_limit(energy_ff);
      lat_now   = 4'd1 + {2'b00, energy_ff[7:6]} + {1'b0, x[2:0]};
      recv_next = recv_ff + 32'd1;
      diff      = $signed({1'b0, lat_now}) - $signed({1'b0, mean_ff});
      diff_mag  = diff[4] ? 4'(-diff) : diff[3:0];
      q_mag     = dvd_step[3:0];
      q_signed  = neg_ff ? 4'(-q_mag) : q_mag;
   end

   always_comb begin
      state_in    = state_ff;
      pps_in      = pps_ff;
      dur_in      = dur_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      rng_in      = rng_ff;
      running_in  = running_ff;
      start_in    = start_ff;
      next_in     = next_ff;
      sent_in     = sent_ff;
      recv_in     = recv_ff;
      lost_in     = lost_ff;
      mean_in     = mean_ff;
      peak_in     = peak_ff;
      now_in      = now_ff;
      energy_in   = energy_ff;
      interval_in = interval_ff;
      n_in        = n_ff;
      drop_in     = drop_ff;
      lat_in      = lat_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      dsr_in      = dsr_ff;
      cnt_in      = cnt_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_PPS:      pps_in  = csr_data[9:0];
            CSR_DURATION: dur_in  = csr_data;
            CSR_CHANNEL:  chan_in = csr_data[6:0];
            CSR_RATE:     rate_in = csr_data[1:0];
            CSR_SEED:     rng_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in    = req_data.now_ms;
               energy_in = req_data.energy;
               n_in      = '0;
               case (req_data.command)
                  CMD_START: begin
                     running_in = 1'b1;
                     start_in   = req_data.now_ms;
                     next_in    = req_data.now_ms;
                     sent_in    = '0;
                     recv_in    = '0;
                     lost_in    = '0;
                     mean_in    = '0;
                     peak_in    = '0;
                  end
                  CMD_STOP: begin
                     running_in = 1'b0;
                     next_in    = '0;
                  end
                  CMD_TICK: begin
                     if (!req_data.replay_busy && running_ff) begin
                        if (start_ff == 64'd0) begin
                           running_in = 1'b1;
                           start_in   = req_data.now_ms;
                           next_in    = req_data.now_ms;
                           sent_in    = '0;
                           recv_in    = '0;
                           lost_in    = '0;
                           mean_in    = '0;
                           peak_in    = '0;
                        end else if (dur_ff != 32'd0 && req_data.now_ms > start_ff &&
                                     (req_data.now_ms - start_ff) >= {32'd0, dur_ff}) begin
                           running_in = 1'b0;
                           next_in    = '0;
                        end else begin
                           rem_in   = '0;
                           dvd_in   = 10'd1000;
                           dsr_in   = {22'd0, pps_clamp};
                           cnt_in   = DivCntW'(DivW);
                           state_in = S_INTDIV;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INTDIV: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff - DivCntW'(1);
            if (cnt_ff == DivCntW'(1)) begin
               interval_in = (dvd_step == '0) ? 10'd1 : dvd_step;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = slot_due ? S_SLOT : S_IDLE;
         end
         S_SLOT: begin
            next_in = next_ff + {54'd0, interval_ff};
            sent_in = sent_ff + 32'd1;
            rng_in  = x;
            drop_in = drop_now;
            state_in = S_OUT;
            if (drop_now) begin
               lat_in  = '0;
               lost_in = lost_ff + 32'd1;
            end else begin
               lat_in  = lat_now;
               recv_in = recv_next;
               if (lat_now > peak_ff) peak_in = lat_now;
               if (recv_next == 32'd1) begin
                  mean_in = lat_now;
               end else if (recv_next != 32'd0) begin
                  // quotient magnitude of |lat - mean| / recv
                  neg_in   = diff[4];
                  rem_in   = '0;
                  dvd_in   = {6'd0, diff_mag};
                  dsr_in   = recv_next;
                  cnt_in   = DivCntW'(DivW);
                  state_in = S_MEANDIV;
               end
            end
         end
         S_MEANDIV: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff - DivCntW'(1);
            if (cnt_ff == DivCntW'(1)) begin
               mean_in  = mean_ff + q_signed;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               n_in     = n_plus[SlotW-1:0];
               state_in = is_last ? S_IDLE : S_SLOT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pps_ff     <= 10'd10;
         dur_ff     <= '0;
         chan_ff    <= '0;
         rate_ff    <= '0;
         rng_ff     <= 32'd1;
         running_ff <= 1'b0;
         start_ff   <= '0;
         next_ff    <= '0;
         sent_ff    <= '0;
         recv_ff    <= '0;
         lost_ff    <= '0;
         mean_ff    <= '0;
         peak_ff    <= '0;
         n_ff       <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pps_ff     <= pps_in;
         dur_ff     <= dur_in;
         chan_ff    <= chan_in;
         rate_ff    <= rate_in;
         rng_ff     <= rng_in;
         running_ff <= running_in;
         start_ff   <= start_in;
         next_ff    <= next_in;
         sent_ff    <= sent_in;
         recv_ff    <= recv_in;
         lost_ff    <= lost_in;
         mean_ff    <= mean_in;
         peak_ff    <= peak_in;
         n_ff       <= n_in;
         cnt_ff     <= cnt_in;
      end
      now_ff      <= now_in;
      energy_ff   <= energy_in;
      interval_ff <= interval_in;
      drop_ff     <= drop_in;
      lat_ff      <= lat_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      rsp_data.dropped        = drop_ff;
      rsp_data.sequence_res   = sent_ff;
      rsp_data.latency_ms     = lat_ff;
      rsp_data.packet_channel = chan_sat;
      rsp_data.packet_rate    = rate_ff;
      rsp_data.timestamp_ms   = now_ff;
      rsp_data.received_total = recv_ff;
      rsp_data.lost_total     = lost_ff;
      rsp_data.latency_mean   = mean_ff;
      rsp_data.latency_peak   = peak_ff;
      rsp_data.last           = is_last;
   end

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid both high");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready)
      else $error("no return to idle after last transfer");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, n_ff} < (SlotW+1)'(MAX_SLOTS_PER_TICK)))
      else $error("too many slots in one tick");

   a_drop_lat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped) |-> (rsp_data.latency_ms == 4'd0))
      else $error("dropped slot carries latency");

endmodule
`default_nettype wire
